FILE: rtl/swm_pkg.sv
// Shared constants and types for the sliding window median filter.
`default_nettype none

package swm_pkg;

  // Window capacity and derived widths.
  localparam int MAX_WINDOW = 32;
  localparam int NCELL      = MAX_WINDOW;
  localparam int DATA_W     = 32;
  localparam int CFG_W      = 6;
  localparam int SLOT_W     = $clog2(MAX_WINDOW);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

  // Window length after reset.
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

  // Cycles spent after the last feed so that every insertion cascade settles.
  localparam int DRAIN_LEN = NCELL + 2;
  localparam int DRAIN_W   = $clog2(DRAIN_LEN + 1);

  // Controls broadcast to every sorting cell.
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/swm_cell.sv
// One sorting cell: keeps the smaller value and hands the larger one onward.
`default_nettype none

module swm_cell
  import swm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cell_ctl_t         ctl,
  input  wire logic [DATA_W-1:0] in_val,
  input  wire logic              in_vld,
  input  wire logic [DATA_W-1:0] right_val,
  output logic      [DATA_W-1:0] held_val,
  output logic      [DATA_W-1:0] pass_val,
  output logic                   pass_vld
);

  logic [DATA_W-1:0] held_r;
  logic              held_vld_r;
  logic [DATA_W-1:0] pass_r;
  logic              pass_vld_r;
  logic              take_new;

  // The incoming value replaces the held one when the cell is empty or it is smaller.
  assign take_new = !held_vld_r || (in_val < held_r);

  // Occupancy and hand-off valid.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      held_vld_r <= 1'b0;
      pass_vld_r <= 1'b0;
    end else if (ctl.shift) begin
      pass_vld_r <= 1'b0;
    end else begin
      pass_vld_r <= in_vld && held_vld_r;
      if (in_vld) begin
        held_vld_r <= 1'b1;
      end
    end
  end

  // Held value and the value handed to the right neighbor.
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      held_r <= right_val;
    end else if (in_vld) begin
      if (take_new) begin
        held_r <= in_val;
        pass_r <= held_r;
      end else begin
        pass_r <= in_val;
      end
    end
  end

  assign held_val = held_r;
  assign pass_val = pass_r;
  assign pass_vld = pass_vld_r;

endmodule

`default_nettype wire

FILE: rtl/swm_chain.sv
// Row of sorting cells; after the feed settles cell 0 holds the smallest value.
`default_nettype none

module swm_chain
  import swm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cell_ctl_t         ctl,
  input  wire logic [DATA_W-1:0] feed_val,
  input  wire logic              feed_vld,
  output logic      [DATA_W-1:0] head_val,
  output logic                   tail_vld
);

  logic [DATA_W-1:0] held   [NCELL];
  logic [DATA_W-1:0] pval   [NCELL];
  logic              pvld   [NCELL];
  logic [DATA_W-1:0] cin_v  [NCELL];
  logic              cin_vl [NCELL];
  logic [DATA_W-1:0] rgt    [NCELL];

  // Wire each cell to its left input and its right neighbor's held value.
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cin_v[i]  = feed_val;
      assign cin_vl[i] = feed_vld;
    end else begin : g_body
      assign cin_v[i]  = pval[i-1];
      assign cin_vl[i] = pvld[i-1];
    end
    if (i == NCELL - 1) begin : g_tail
      assign rgt[i] = '0;
    end else begin : g_mid
      assign rgt[i] = held[i+1];
    end

    swm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .in_val    (cin_v[i]),
      .in_vld    (cin_vl[i]),
      .right_val (rgt[i]),
      .held_val  (held[i]),
      .pass_val  (pval[i]),
      .pass_vld  (pvld[i])
    );
  end

  assign head_val = held[0];
  // A value leaving the last cell would mean an overfilled row.
  assign tail_vld = pvld[NCELL-1];

endmodule

`default_nettype wire

FILE: rtl/sliding_window_median.sv
// Top level of the sliding window median filter: window memory, sequencer, cell row.
//
//   Port group    Direction  Handshake          Payload
//   in_*          input      in_valid/in_ready  in_sample[31:0]
//   out_*         output     out_valid/out_ready out_median[31:0], out_window_wrapped
//   cfg_*         input      cfg_wr_en          cfg_wr_data[5:0] (window length)
//
// A beat accepts the sample, reads the N samples held from the window memory into the
// cell row through its single read port, lets the insertion cascade settle, shifts the
// row toward cell 0 until the middle pair has passed, and loads the result.
// Reset (rst_n low, synchronous) empties the window and sets the length to 8.
// A finished result waits in the output register while the next beat is taken;
// a stalled output only holds the sequencer when it has the next result ready.
`default_nettype none

module sliding_window_median
  import swm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [DATA_W-1:0] in_sample,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [DATA_W-1:0] out_median,
  output logic                   out_window_wrapped,
  input  wire logic              cfg_wr_en,
  input  wire logic [CFG_W-1:0]  cfg_wr_data
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FEED  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_SHIFT = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CFG_W-1:0]   win_len_r;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [SLOT_W-1:0]  wslot_r, wslot_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               wrap_r, wrap_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [DRAIN_W-1:0] drain_r, drain_nxt;
  logic [DATA_W-1:0]  lo_r, hi_r;
  logic               out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]  out_median_r;
  logic               out_wrap_r;

  logic [DATA_W-1:0]  mem [MAX_WINDOW];
  logic [DATA_W-1:0]  mem_q_r;
  logic               feed_vld_r;

  logic [CNT_W-1:0]   eff_len;
  logic [SLOT_W-1:0]  put_slot;
  logic [CNT_W-1:0]   slot_inc;
  logic               accept;
  logic               out_load;
  logic [CNT_W-1:0]   mid;
  logic [DATA_W:0]    pair_sum;
  logic [DATA_W-1:0]  head_val;
  logic               tail_vld;
  cell_ctl_t          ctl;

  // Window length register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      win_len_r <= cfg_wr_data;
    end
  end

  // Zero length acts as one; lengths above capacity saturate.
  always_comb begin
    if (win_len_r == '0) begin
      eff_len = CNT_W'(1);
    end else if (32'(win_len_r) > MAX_WINDOW) begin
      eff_len = CNT_W'(MAX_WINDOW);
    end else begin
      eff_len = CNT_W'(win_len_r);
    end
  end

  // Slot for the incoming sample and where the ring goes next.
  assign put_slot = (CNT_W'(wslot_r) >= eff_len) ? '0 : wslot_r;
  assign slot_inc = CNT_W'(put_slot) + CNT_W'(1);

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);
  assign mid      = count_r >> 1;
  assign pair_sum = {1'b0, lo_r} + {1'b0, hi_r};

  // Sequencer next state.
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    wslot_nxt     = wslot_r;
    count_nxt     = count_r;
    wrap_nxt      = wrap_r;
    idx_nxt       = idx_r;
    drain_nxt     = drain_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ctl.clear     = 1'b0;
    ctl.shift     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          fill_nxt  = (fill_r < eff_len) ? fill_r + CNT_W'(1) : eff_len;
          count_nxt = (fill_r < eff_len) ? fill_r + CNT_W'(1) : eff_len;
          wrap_nxt  = (slot_inc >= eff_len);
          wslot_nxt = (slot_inc >= eff_len) ? '0 : slot_inc[SLOT_W-1:0];
          idx_nxt   = '0;
          ctl.clear = 1'b1;
          state_nxt = ST_FEED;
        end
      end
      ST_FEED: begin
        if (idx_r == count_r - CNT_W'(1)) begin
          drain_nxt = '0;
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      ST_DRAIN: begin
        if (drain_r == DRAIN_W'(DRAIN_LEN - 1)) begin
          idx_nxt   = '0;
          state_nxt = ST_SHIFT;
        end else begin
          drain_nxt = drain_r + DRAIN_W'(1);
        end
      end
      ST_SHIFT: begin
        ctl.shift = 1'b1;
        idx_nxt   = idx_r + CNT_W'(1);
        if (idx_r == mid) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      wslot_r     <= '0;
      out_valid_r <= 1'b0;
      feed_vld_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      wslot_r     <= wslot_nxt;
      out_valid_r <= out_valid_nxt;
      feed_vld_r  <= (state_r == ST_FEED);
    end
  end

  // Working registers of the current beat.
  always_ff @(posedge clk) begin
    count_r <= count_nxt;
    wrap_r  <= wrap_nxt;
    idx_r   <= idx_nxt;
    drain_r <= drain_nxt;
  end

  // Window memory: written on accept, read once per feed cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[put_slot] <= in_sample;
    end
    mem_q_r <= mem[idx_r[SLOT_W-1:0]];
  end

  swm_chain u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .feed_val (mem_q_r),
    .feed_vld (feed_vld_r),
    .head_val (head_val),
    .tail_vld (tail_vld)
  );

  // Catch the middle pair as the sorted row shifts out through cell 0.
  always_ff @(posedge clk) begin
    if (state_r == ST_SHIFT) begin
      if (idx_r == mid - CNT_W'(1)) begin
        lo_r <= head_val;
      end
      if (idx_r == mid) begin
        hi_r <= head_val;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_median_r <= count_r[0] ? hi_r : pair_sum[DATA_W:1];
      out_wrap_r   <= wrap_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_median         = out_median_r;
  assign out_window_wrapped = out_wrap_r;

`ifndef SYNTHESIS
  a_accept_feeds: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_FEED))
    else $error("accepted beat did not start the feed");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_OUT))
    else $error("result appeared outside the output step");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (count_r != '0) && (32'(count_r) <= MAX_WINDOW))
    else $error("window count out of range during a beat");

  a_row_not_overfilled: assert property (@(posedge clk) disable iff (!rst_n)
    !tail_vld)
    else $error("value fell off the end of the cell row");
`endif

endmodule

`default_nettype wire
